// ===== hw/rtl/encoder_frame_position_tracker_macros.svh =====
// Assertion macros for the encoder frame position tracker.
`ifndef ENCODER_FRAME_POSITION_TRACKER_MACROS_SVH
`define ENCODER_FRAME_POSITION_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
`define EFPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define EFPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define EFPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define EFPT_ASSERT(lbl, prop, msg)
`define EFPT_ASSERT_SAME(lbl, ante, cons, msg)
`define EFPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/efpt_pkg.sv =====
// Shared types, widths and constants of the encoder frame position tracker.
package efpt_pkg;

  localparam int ZERO_W   = 16;
  localparam int WRAP_W   = 16;
  localparam int JUMP_W   = 17;
  localparam int WIN_W    = 32;
  localparam int TPM_W    = 12;
  localparam int CFG_DW   = 32;
  localparam int CFG_IW   = 3;
  localparam int RAW_W    = 16;
  localparam int POS_W    = 18;
  localparam int DIFF_W   = POS_W + 1;
  localparam int MAG_W    = POS_W;
  localparam int SPD_W    = 24;
  localparam int SCALE_SH = 8;
  localparam int PROD_W   = MAG_W + TPM_W;
  localparam int NUM_W    = PROD_W + SCALE_SH;
  localparam int CNT_W    = $clog2(NUM_W);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  localparam logic [ZERO_W-1:0] RST_ZERO_OFFSET    = ZERO_W'(0);
  localparam logic [WRAP_W-1:0] RST_WRAP_LIMIT     = WRAP_W'(32767);
  localparam logic [JUMP_W-1:0] RST_JUMP_THRESHOLD = JUMP_W'(100);
  localparam logic [WIN_W-1:0]  RST_SPEED_WINDOW   = WIN_W'(60000);
  localparam logic [TPM_W-1:0]  RST_TICKS_PER_MS   = TPM_W'(1000);

  localparam logic [7:0] SYNC_B0  = 8'hFF;
  localparam logic [7:0] SYNC_B1  = 8'h81;
  localparam logic [7:0] SYNC_B2  = 8'h00;
  localparam logic [7:0] CHK_BASE = 8'h80;

  localparam logic signed [POS_W-1:0] WRAP_SPAN = POS_W'(65535);

  localparam logic [NUM_W-1:0] SPD_POS_LIM = NUM_W'((64'd1 << (SPD_W - 1)) - 64'd1);
  localparam logic [NUM_W-1:0] SPD_NEG_LIM = NUM_W'(64'd1 << (SPD_W - 1));
  localparam logic signed [SPD_W-1:0] SPEED_MAX = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic signed [SPD_W-1:0] SPEED_MIN = {1'b1, {(SPD_W-1){1'b0}}};

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ZERO_OFFSET    = 3'd0,
    CFG_WRAP_LIMIT     = 3'd1,
    CFG_JUMP_THRESHOLD = 3'd2,
    CFG_SPEED_WINDOW   = 3'd3,
    CFG_TICKS_PER_MS   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    HDR_NONE = 2'd0,
    HDR_FF   = 2'd1,
    HDR_81   = 2'd2,
    HDR_BODY = 2'd3
  } hdr_t;

  typedef enum logic [1:0] {
    BODY_HIGH  = 2'd0,
    BODY_LOW   = 2'd1,
    BODY_CHECK = 2'd2,
    BODY_SPARE = 2'd3
  } body_t;

  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_POS   = 2'd1,
    DIR_NEG   = 2'd2
  } dir_t;

  typedef struct packed {
    logic [ZERO_W-1:0] zero_offset;
    logic [WRAP_W-1:0] wrap_limit;
    logic [JUMP_W-1:0] jump_threshold;
    logic [WIN_W-1:0]  speed_window;
    logic [TPM_W-1:0]  ticks_per_ms;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic pos_calc;
    logic upd;
    logic mul_load;
    logic div_step;
    logic sat;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic speed_go;
    logic div_last;
  } stat_t;

endpackage

// ===== hw/rtl/efpt_ctrl.sv =====
// Sequencer: handshakes, frame evaluation steps and divider control.
module efpt_ctrl
  import efpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POS  = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_SAT  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && stat.frame_end) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        cmd.pos_calc = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = stat.speed_go ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/efpt_dp.sv =====
// Datapath: frame parser, position filter, speed divider and result register.
module efpt_dp
  import efpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  cfg_t                    cfg,
  input  logic                    in_req_type,
  input  logic [7:0]              in_rx_byte,
  output stat_t                   stat,
  output logic                    out_frame_status,
  output logic [RAW_W-1:0]        out_raw_value,
  output logic signed [POS_W-1:0] out_new_position,
  output logic signed [POS_W-1:0] out_held_position,
  output logic                    out_first_frame,
  output logic                    out_speed_updated,
  output logic signed [SPD_W-1:0] out_speed_q8,
  output logic [1:0]              out_direction
);

  // parser and tracking state
  hdr_t                    hdr_r, hdr_nxt;
  body_t                   body_r, body_nxt;
  logic [7:0]              vh_r, vl_r, chk_r;
  logic                    started_r;
  logic signed [POS_W-1:0] stored_r, prev_r;
  logic [WIN_W-1:0]        elapsed_r, elapsed_nxt;
  logic signed [SPD_W-1:0] speed_r;

  // per-frame working registers
  logic                    bad_r;
  logic signed [POS_W-1:0] pos_r;
  logic                    first_r, supd_r, neg_r;
  logic [MAG_W-1:0]        mag_r;
  logic [WIN_W-1:0]        den_r, rem_r;
  logic [NUM_W-1:0]        num_r;
  logic [CNT_W-1:0]        cnt_r;

  logic                    is_byte;
  logic [RAW_W-1:0]        raw;
  logic [7:0]              sum;
  logic signed [POS_W-1:0] stride, wrap_s, unw;
  logic signed [POS_W-1:0] stored_eff, prev_eff;
  logic [WIN_W-1:0]        elap_eff;
  logic signed [DIFF_W-1:0] jd, sd;
  logic [DIFF_W-1:0]       jabs, sabs;
  logic                    follow, go;
  logic [PROD_W-1:0]       prod;
  logic [WIN_W:0]          trial, tdiff;
  logic                    ge;
  logic signed [SPD_W-1:0] sat_val;
  dir_t                    dir;

  assign is_byte        = (in_req_type == REQ_BYTE);
  assign stat.frame_end = is_byte && (hdr_r == HDR_BODY) && (body_r == BODY_SPARE);

  // header search and body capture
  always_comb begin
    hdr_nxt  = hdr_r;
    body_nxt = body_r;
    if (cmd.accept && is_byte) begin
      if (hdr_r != HDR_BODY) begin
        if (hdr_r == HDR_FF && in_rx_byte == SYNC_B1) begin
          hdr_nxt = HDR_81;
        end else if (hdr_r == HDR_81 && in_rx_byte == SYNC_B2) begin
          hdr_nxt  = HDR_BODY;
          body_nxt = BODY_HIGH;
        end else begin
          // an FF anywhere restarts the match one byte in
          hdr_nxt = (in_rx_byte == SYNC_B0) ? HDR_FF : HDR_NONE;
        end
      end else begin
        case (body_r)
          BODY_HIGH:  body_nxt = BODY_LOW;
          BODY_LOW:   body_nxt = BODY_CHECK;
          BODY_CHECK: body_nxt = BODY_SPARE;
          default: begin
            hdr_nxt  = HDR_NONE;
            body_nxt = BODY_HIGH;
          end
        endcase
      end
    end
  end

  // position of the captured frame
  assign raw    = {vh_r, vl_r};
  assign sum    = 8'(CHK_BASE + vh_r + vl_r);
  assign stride = $signed({2'b00, raw}) - $signed({2'b00, cfg.zero_offset});
  assign wrap_s = $signed({2'b00, cfg.wrap_limit});

  always_comb begin
    if (stride > wrap_s) begin
      unw = stride - WRAP_SPAN;
    end else if (stride < -wrap_s) begin
      unw = stride + WRAP_SPAN;
    end else begin
      unw = stride;
    end
  end

  // first good frame seeds the tracking state
  assign stored_eff = started_r ? stored_r : pos_r;
  assign prev_eff   = started_r ? prev_r : pos_r;
  assign elap_eff   = started_r ? elapsed_r : '0;

  assign jd     = DIFF_W'(stored_eff) - DIFF_W'(pos_r);
  assign jabs   = jd[DIFF_W-1] ? DIFF_W'(-jd) : DIFF_W'(jd);
  assign follow = jabs < {{(DIFF_W-JUMP_W){1'b0}}, cfg.jump_threshold};
  assign go     = elap_eff > cfg.speed_window;
  assign sd     = DIFF_W'(pos_r) - DIFF_W'(prev_eff);
  assign sabs   = sd[DIFF_W-1] ? DIFF_W'(-sd) : DIFF_W'(sd);

  assign stat.speed_go = !bad_r && go;

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (cmd.accept && !is_byte && (elapsed_r != '1)) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end
    if (cmd.upd && !bad_r) begin
      elapsed_nxt = go ? '0 : elap_eff;
    end
  end

  // scaled delta and one quotient bit per step
  assign prod          = mag_r * cfg.ticks_per_ms;
  assign trial         = {rem_r, num_r[NUM_W-1]};
  assign tdiff         = trial - {1'b0, den_r};
  assign ge            = (trial >= {1'b0, den_r});
  assign stat.div_last = (cnt_r == DIV_LAST);

  always_comb begin
    if (!neg_r) begin
      sat_val = (num_r > SPD_POS_LIM) ? SPEED_MAX : $signed(num_r[SPD_W-1:0]);
    end else begin
      sat_val = (num_r > SPD_NEG_LIM) ? SPEED_MIN : $signed(-num_r[SPD_W-1:0]);
    end
  end

  always_comb begin
    if (speed_r == '0) begin
      dir = DIR_STILL;
    end else if (speed_r[SPD_W-1]) begin
      dir = DIR_NEG;
    end else begin
      dir = DIR_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= HDR_NONE;
      body_r    <= BODY_HIGH;
      vh_r      <= '0;
      vl_r      <= '0;
      chk_r     <= '0;
      started_r <= 1'b0;
      stored_r  <= '0;
      prev_r    <= '0;
      elapsed_r <= '0;
      speed_r   <= '0;
      cnt_r     <= '0;
    end else begin
      hdr_r     <= hdr_nxt;
      body_r    <= body_nxt;
      elapsed_r <= elapsed_nxt;
      if (cmd.accept && is_byte && hdr_r == HDR_BODY) begin
        case (body_r)
          BODY_HIGH:  vh_r  <= in_rx_byte;
          BODY_LOW:   vl_r  <= in_rx_byte;
          BODY_CHECK: chk_r <= in_rx_byte;
          default: ;
        endcase
      end
      if (cmd.upd && !bad_r) begin
        started_r <= 1'b1;
        stored_r  <= follow ? pos_r : stored_eff;
        prev_r    <= go ? pos_r : prev_eff;
      end
      if (cmd.mul_load) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.sat) begin
        speed_r <= sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_calc) begin
      bad_r <= (sum != chk_r);
      pos_r <= (sum != chk_r) ? '0 : -unw;
    end
    if (cmd.upd) begin
      first_r <= !bad_r && !started_r;
      supd_r  <= !bad_r && go;
      den_r   <= elap_eff;
      neg_r   <= sd[DIFF_W-1];
      mag_r   <= sabs[MAG_W-1:0];
    end
    if (cmd.mul_load) begin
      num_r <= {prod, {SCALE_SH{1'b0}}};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? tdiff[WIN_W-1:0] : trial[WIN_W-1:0];
    end
    if (cmd.load_out) begin
      out_frame_status  <= bad_r;
      out_raw_value     <= raw;
      out_new_position  <= pos_r;
      out_held_position <= stored_r;
      out_first_frame   <= first_r;
      out_speed_updated <= supd_r;
      out_speed_q8      <= speed_r;
      out_direction     <= dir;
    end
  end

endmodule

// ===== hw/rtl/encoder_frame_position_tracker.sv =====
// Encoder frame position tracker: serial frame parser with position and speed tracking.
// A tick or a byte that does not end a frame leaves the block idle, so ready stays high.
// The last byte of a frame holds the input through states POS and UPD, then, when speed is
// measured, MUL, the 38-step shift-subtract divider and SAT, then OUT until output is free.
// The result register is loaded in OUT and stays valid until the receiver takes it.
// Synchronous active-low reset clears the parser and tracking state, loads register defaults.
`include "encoder_frame_position_tracker_macros.svh"

module encoder_frame_position_tracker
  import efpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_frame_status,
  output logic [RAW_W-1:0]        out_raw_value,
  output logic signed [POS_W-1:0] out_new_position,
  output logic signed [POS_W-1:0] out_held_position,
  output logic                    out_first_frame,
  output logic                    out_speed_updated,
  output logic signed [SPD_W-1:0] out_speed_q8,
  output logic [1:0]              out_direction,
  input  logic                    cfg_we,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_wdata
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;
  logic  frame_taken;
  logic  first_shown;
  logic  speed_shown;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_offset    <= RST_ZERO_OFFSET;
      cfg_r.wrap_limit     <= RST_WRAP_LIMIT;
      cfg_r.jump_threshold <= RST_JUMP_THRESHOLD;
      cfg_r.speed_window   <= RST_SPEED_WINDOW;
      cfg_r.ticks_per_ms   <= RST_TICKS_PER_MS;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ZERO_OFFSET:    cfg_r.zero_offset    <= cfg_wdata[ZERO_W-1:0];
        CFG_WRAP_LIMIT:     cfg_r.wrap_limit     <= cfg_wdata[WRAP_W-1:0];
        CFG_JUMP_THRESHOLD: cfg_r.jump_threshold <= cfg_wdata[JUMP_W-1:0];
        CFG_SPEED_WINDOW:   cfg_r.speed_window   <= cfg_wdata[WIN_W-1:0];
        CFG_TICKS_PER_MS:   cfg_r.ticks_per_ms   <= cfg_wdata[TPM_W-1:0];
        default: ;
      endcase
    end
  end

  efpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  efpt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg_r),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .stat              (stat),
    .out_frame_status  (out_frame_status),
    .out_raw_value     (out_raw_value),
    .out_new_position  (out_new_position),
    .out_held_position (out_held_position),
    .out_first_frame   (out_first_frame),
    .out_speed_updated (out_speed_updated),
    .out_speed_q8      (out_speed_q8),
    .out_direction     (out_direction)
  );

  assign frame_taken = in_valid && in_ready && stat.frame_end;
  assign first_shown = out_valid && out_first_frame;
  assign speed_shown = out_valid && out_speed_updated;

  `EFPT_ASSERT(a_cmd_excl, $onehot0(cmd), "more than one datapath command active")
  `EFPT_ASSERT_NEXT(a_frame_hold, frame_taken, !in_ready, "input taken during evaluation")
  `EFPT_ASSERT_SAME(a_first_pos, first_shown, out_held_position == out_new_position, "first seed")
  `EFPT_ASSERT_SAME(a_speed_good, speed_shown, !out_frame_status, "speed measured on a bad frame")

endmodule

// ===== tb/efpt_frame_checker.sv =====
// Frame result checker: tracks the encoder state from accepted words and compares each result.
`timescale 1ns / 100ps

module efpt_frame_checker
  import efpt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_req_type,
  input  logic [7:0]              in_rx_byte,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_frame_status,
  input  logic [RAW_W-1:0]        out_raw_value,
  input  logic signed [POS_W-1:0] out_new_position,
  input  logic signed [POS_W-1:0] out_held_position,
  input  logic                    out_first_frame,
  input  logic                    out_speed_updated,
  input  logic signed [SPD_W-1:0] out_speed_q8,
  input  logic [1:0]              out_direction,
  input  logic                    cfg_we,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_wdata,
  output int                      fail_count,
  output int                      frames_waiting,
  output int                      frames_checked,
  output int                      speed_frames
);

  typedef struct packed {
    logic                    status;
    logic [RAW_W-1:0]        raw;
    logic signed [POS_W-1:0] new_pos;
    logic signed [POS_W-1:0] held_pos;
    logic                    first;
    logic                    spd_upd;
    logic signed [SPD_W-1:0] speed;
    logic [1:0]              dir;
  } frame_result_t;

  frame_result_t pending_frames[$];

  cfg_t                    setting;
  hdr_t                    hdr;
  body_t                   body;
  logic [7:0]              val_hi;
  logic [7:0]              val_lo;
  logic [7:0]              chk;
  logic                    started;
  logic signed [POS_W-1:0] held;
  logic signed [POS_W-1:0] prev;
  logic [WIN_W-1:0]        elapsed;
  logic signed [SPD_W-1:0] speed;

  int n_bad;
  int n_checked;
  int n_speed;

  // Advance the tracker by one word; return 1 when the word closes a frame.
  function automatic bit track_word(input logic req, input logic [7:0] b,
                                    output frame_result_t r);
    longint stride;
    longint pos;
    longint jump;
    longint rate;
    longint held_l;
    longint prev_l;
    logic [7:0] sum;
    r = '0;
    if (req == REQ_TICK) begin
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      return 1'b0;
    end
    if (hdr != HDR_BODY) begin
      if (hdr == HDR_FF && b == SYNC_B1) hdr = HDR_81;
      else if (hdr == HDR_81 && b == SYNC_B2) begin
        hdr = HDR_BODY;
        body = BODY_HIGH;
      end else if (b == SYNC_B0) hdr = HDR_FF;
      else hdr = HDR_NONE;
      return 1'b0;
    end
    if (body != BODY_SPARE) begin
      case (body)
        BODY_HIGH: begin
          val_hi = b;
          body = BODY_LOW;
        end
        BODY_LOW: begin
          val_lo = b;
          body = BODY_CHECK;
        end
        default: begin
          chk = b;
          body = BODY_SPARE;
        end
      endcase
      return 1'b0;
    end
    hdr = HDR_NONE;
    body = BODY_HIGH;
    r.raw = {val_hi, val_lo};
    sum = CHK_BASE + val_hi + val_lo;
    r.status = (sum != chk);
    pos = 0;
    if (!r.status) begin
      stride = longint'(r.raw) - longint'(setting.zero_offset);
      if (stride > longint'(setting.wrap_limit)) pos = stride - WRAP_SPAN;
      else if (-stride > longint'(setting.wrap_limit)) pos = stride + WRAP_SPAN;
      else pos = stride;
      pos = -pos;
      if (!started) begin
        held = pos[POS_W-1:0];
        prev = pos[POS_W-1:0];
        elapsed = '0;
        started = 1'b1;
        r.first = 1'b1;
      end
      held_l = held;
      jump = held_l - pos;
      if (jump < 0) jump = -jump;
      if (jump < longint'(setting.jump_threshold)) held = pos[POS_W-1:0];
      if (longint'(elapsed) > longint'(setting.speed_window)) begin
        prev_l = prev;
        rate = (pos - prev_l) * longint'(setting.ticks_per_ms) * 256;
        rate = rate / longint'(elapsed);
        if (rate > SPEED_MAX) rate = SPEED_MAX;
        if (rate < SPEED_MIN) rate = SPEED_MIN;
        speed = rate[SPD_W-1:0];
        elapsed = '0;
        prev = pos[POS_W-1:0];
        r.spd_upd = 1'b1;
      end
    end
    r.new_pos = pos[POS_W-1:0];
    r.held_pos = held;
    r.speed = speed;
    if (speed > 0) r.dir = DIR_POS;
    else if (speed < 0) r.dir = DIR_NEG;
    else r.dir = DIR_STILL;
    return 1'b1;
  endfunction

  function automatic void cmp_field(input string name, input logic [SPD_W-1:0] want,
                                    input logic [SPD_W-1:0] got);
    if (got !== want) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%0t: frame %0d %s mismatch: expected %0h, got %0h",
                 $realtime, n_checked, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t fresh;
    if (!rst_n) begin
      setting.zero_offset    = RST_ZERO_OFFSET;
      setting.wrap_limit     = RST_WRAP_LIMIT;
      setting.jump_threshold = RST_JUMP_THRESHOLD;
      setting.speed_window   = RST_SPEED_WINDOW;
      setting.ticks_per_ms   = RST_TICKS_PER_MS;
      hdr = HDR_NONE;
      body = BODY_HIGH;
      val_hi = '0;
      val_lo = '0;
      chk = '0;
      started = 1'b0;
      held = '0;
      prev = '0;
      elapsed = '0;
      speed = '0;
      pending_frames.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: result with no frame waiting (raw %0h)", $realtime, out_raw_value);
        end else begin
          want = pending_frames.pop_front();
          cmp_field("frame_status", want.status, out_frame_status);
          cmp_field("raw_value", want.raw, out_raw_value);
          cmp_field("new_position", want.new_pos, out_new_position);
          cmp_field("held_position", want.held_pos, out_held_position);
          cmp_field("first_frame", want.first, out_first_frame);
          cmp_field("speed_updated", want.spd_upd, out_speed_updated);
          cmp_field("speed_q8", want.speed, out_speed_q8);
          cmp_field("direction", want.dir, out_direction);
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (track_word(in_req_type, in_rx_byte, fresh)) begin
          pending_frames.push_back(fresh);
          if (fresh.spd_upd) n_speed++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZERO_OFFSET:    setting.zero_offset    = cfg_wdata[ZERO_W-1:0];
          CFG_WRAP_LIMIT:     setting.wrap_limit     = cfg_wdata[WRAP_W-1:0];
          CFG_JUMP_THRESHOLD: setting.jump_threshold = cfg_wdata[JUMP_W-1:0];
          CFG_SPEED_WINDOW:   setting.speed_window   = cfg_wdata[WIN_W-1:0];
          CFG_TICKS_PER_MS:   setting.ticks_per_ms   = cfg_wdata[TPM_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count     <= n_bad;
    frames_waiting <= pending_frames.size();
    frames_checked <= n_checked;
    speed_frames   <= n_speed;
  end

endmodule

// ===== tb/encoder_frame_position_tracker_tb.sv =====
// Testbench top for the encoder frame position tracker: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module encoder_frame_position_tracker_tb;
  import efpt_pkg::*;

  localparam int SETTLE_CYCLES  = 64;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n;

  logic                    in_valid;
  logic                    in_ready;
  logic                    in_req_type;
  logic [7:0]              in_rx_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_frame_status;
  logic [RAW_W-1:0]        out_raw_value;
  logic signed [POS_W-1:0] out_new_position;
  logic signed [POS_W-1:0] out_held_position;
  logic                    out_first_frame;
  logic                    out_speed_updated;
  logic signed [SPD_W-1:0] out_speed_q8;
  logic [1:0]              out_direction;
  logic                    cfg_we;
  logic [CFG_IW-1:0]       cfg_index;
  logic [CFG_DW-1:0]       cfg_wdata;

  int n_fail;
  int n_pending;
  int n_checked;
  int n_speed;

  int   n_sent;
  int   n_settings;
  int   idle_cycles;
  bit   tx_idle_en;
  bit   rx_idle_en;
  bit   rx_hold_req;
  cfg_t cur_set;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  encoder_frame_position_tracker DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_status  (out_frame_status),
    .out_raw_value     (out_raw_value),
    .out_new_position  (out_new_position),
    .out_held_position (out_held_position),
    .out_first_frame   (out_first_frame),
    .out_speed_updated (out_speed_updated),
    .out_speed_q8      (out_speed_q8),
    .out_direction     (out_direction),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  efpt_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_status  (out_frame_status),
    .out_raw_value     (out_raw_value),
    .out_new_position  (out_new_position),
    .out_held_position (out_held_position),
    .out_first_frame   (out_first_frame),
    .out_speed_updated (out_speed_updated),
    .out_speed_q8      (out_speed_q8),
    .out_direction     (out_direction),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (n_fail),
    .frames_waiting    (n_pending),
    .frames_checked    (n_checked),
    .speed_frames      (n_speed)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t s;
    s.zero_offset    = ZERO_W'($urandom);
    s.wrap_limit     = WRAP_W'($urandom);
    s.jump_threshold = JUMP_W'($urandom_range(0, 600));
    s.speed_window   = WIN_W'($urandom_range(0, 30));
    s.ticks_per_ms   = TPM_W'($urandom_range(1, 4095));
    return s;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic req, input logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // Send the n low bytes of seq, most significant first.
  task automatic send_bytes(input logic [63:0] seq, input int n);
    for (int i = n - 1; i >= 0; i--) send_word(REQ_BYTE, seq[8*i +: 8]);
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) send_word(REQ_TICK, 8'($urandom));
  endtask

  task automatic send_frame();
    logic [15:0] v;
    logic [7:0]  ck;
    repeat ($urandom_range(0, 9)) send_word(REQ_TICK, 8'($urandom));
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_word(REQ_BYTE, 8'($urandom));
    case ($urandom_range(0, 9))
      0: send_bytes({SYNC_B0, SYNC_B0, SYNC_B1, SYNC_B2}, 4);
      1: begin
        // broken header first, then a clean one
        send_bytes({SYNC_B0, SYNC_B1, 8'($urandom)}, 3);
        send_bytes({SYNC_B0, SYNC_B1, SYNC_B2}, 3);
      end
      default: send_bytes({SYNC_B0, SYNC_B1, SYNC_B2}, 3);
    endcase
    case ($urandom_range(0, 5))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = 16'($urandom);
      default: v = cur_set.zero_offset + 16'($urandom_range(0, 400)) - 16'd200;
    endcase
    ck = CHK_BASE + v[15:8] + v[7:0];
    if ($urandom_range(0, 5) == 0) ck = 8'($urandom);
    maybe_ticks();
    send_word(REQ_BYTE, v[15:8]);
    maybe_ticks();
    send_word(REQ_BYTE, v[7:0]);
    maybe_ticks();
    send_word(REQ_BYTE, ck);
    maybe_ticks();
    send_word(REQ_BYTE, 8'($urandom));
  endtask

  task automatic feed(input int n);
    int stop_at;
    stop_at = n_sent + n;
    while (n_sent < stop_at) send_frame();
  endtask

  // Drop valid and wait until every predicted frame has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ZERO_OFFSET;
    cfg_wdata <= CFG_DW'(s.zero_offset);
    @(posedge clk);
    cfg_index <= CFG_WRAP_LIMIT;
    cfg_wdata <= CFG_DW'(s.wrap_limit);
    @(posedge clk);
    cfg_index <= CFG_JUMP_THRESHOLD;
    cfg_wdata <= CFG_DW'(s.jump_threshold);
    @(posedge clk);
    cfg_index <= CFG_SPEED_WINDOW;
    cfg_wdata <= CFG_DW'(s.speed_window);
    @(posedge clk);
    cfg_index <= CFG_TICKS_PER_MS;
    cfg_wdata <= CFG_DW'(s.ticks_per_ms);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_set = s;
    n_settings++;
  endtask

  task automatic run_phase(input cfg_t s, input int n, input bit idle, input bit hold);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    load_settings(s);
    tx_idle_en  = idle;
    rx_idle_en  = idle;
    rx_hold_req = hold;
    feed(n);
  endtask

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("** encoder_frame_position_tracker: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t s;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_BYTE;
    in_rx_byte  = 8'h00;
    cfg_we      = 1'b0;
    cfg_index   = CFG_ZERO_OFFSET;
    cfg_wdata   = '0;
    idle_cycles = 0;
    n_sent      = 0;
    n_settings  = 1;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    rx_hold_req = 1'b0;
    cur_set.zero_offset    = RST_ZERO_OFFSET;
    cur_set.wrap_limit     = RST_WRAP_LIMIT;
    cur_set.jump_threshold = RST_JUMP_THRESHOLD;
    cur_set.speed_window   = RST_SPEED_WINDOW;
    cur_set.ticks_per_ms   = RST_TICKS_PER_MS;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset settings: resync on a doubled FF, first frame at raw zero,
    // a tick, a stray byte, raw all ones, then a bad check with a header in its body.
    send_bytes({SYNC_B0, SYNC_B0, SYNC_B1, SYNC_B2, 8'h00, 8'h00, CHK_BASE, 8'hAA}, 8);
    send_word(REQ_TICK, 8'hFF);
    send_word(REQ_BYTE, SYNC_B1);
    send_bytes({SYNC_B0, SYNC_B1, SYNC_B2, 8'hFF, 8'hFF, 8'h7E, 8'h55}, 7);
    send_bytes({SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B0, SYNC_B1, 8'h12, SYNC_B2}, 7);

    s = pick_settings();
    s.speed_window = 5;
    run_phase(s, 90, 1'b1, 1'b1);

    // Low extremes, no idling; pause mid-phase until all frames are out.
    s.zero_offset    = '0;
    s.wrap_limit     = '0;
    s.jump_threshold = '0;
    s.speed_window   = 1;
    s.ticks_per_ms   = '1;
    run_phase(s, 35, 1'b0, 1'b0);
    drain_results();
    feed(35);

    s.zero_offset    = '1;
    s.wrap_limit     = '1;
    s.jump_threshold = '1;
    s.speed_window   = '0;
    s.ticks_per_ms   = 1;
    run_phase(s, 70, 1'b1, 1'b0);

    s = pick_settings();
    s.speed_window = '1;
    run_phase(s, 70, 1'b1, 1'b0);

    s = pick_settings();
    s.ticks_per_ms = '0;
    s.speed_window = 3;
    run_phase(s, 70, 1'b1, 1'b0);

    run_phase(pick_settings(), 50, 1'b1, 1'b0);
    run_phase(pick_settings(), 50, 1'b1, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words under %0d register settings; %0d frame results checked,",
             n_sent, n_settings, n_checked);
    $display("%0d of them with a speed measurement, including resync, bad check and stalls.",
             n_speed);
    if (n_fail == 0 && n_pending == 0) begin
      $display("** encoder_frame_position_tracker: PASSED **");
    end else begin
      $display("%0d mismatches, %0d frames never came out", n_fail, n_pending);
      $display("** encoder_frame_position_tracker: FAILED **");
    end
    $finish;
  end

endmodule
